// ===== src/cdd_pkg.sv =====
// Shared types and constants for the cascade differential-drive PID block:
// register map, configuration bundle, and controller-to-datapath commands.
// No dependencies.
`default_nettype none

package cdd_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ERROR_TO_DIFF_SCALE,
        REG_DIFF_LIMIT,
        REG_SMOOTHING_WEIGHT,
        REG_PROP_GAIN,
        REG_INTEG_GAIN,
        REG_DERIV_GAIN,
        REG_INTEG_LIMIT,
        REG_DRIVE_LIMIT
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] error_to_diff_scale;
        logic [14:0] diff_limit;
        logic [15:0] smoothing_weight;
        logic [23:0] prop_gain;
        logic [23:0] integ_gain;
        logic [23:0] deriv_gain;
        logic [22:0] integ_limit;
        logic [14:0] drive_limit;
    } cfg_t;

    localparam logic [15:0] SCALE_RST       = 16'd655;
    localparam logic [14:0] DIFF_LIMIT_RST  = 15'd6144;
    localparam logic [15:0] WEIGHT_RST      = 16'd13107;
    localparam logic [23:0] PROP_GAIN_RST   = 24'd40960;
    localparam logic [23:0] INTEG_GAIN_RST  = 24'd2048;
    localparam logic [23:0] DERIV_GAIN_RST  = 24'd410;
    localparam logic [22:0] INTEG_LIMIT_RST = 23'd409600;
    localparam logic [14:0] DRIVE_LIMIT_RST = 15'd1000;

    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_CAPTURE,
        STEP_DIFF,
        STEP_RAW,
        STEP_DELTA,
        STEP_TARGET_L,
        STEP_TARGET_R,
        STEP_ERR,
        STEP_SUM,
        STEP_DRIVE_L,
        STEP_DRIVE_R,
        STEP_OUT
    } step_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_LAT,
        MUL_SMOOTH_L,
        MUL_SMOOTH_R,
        MUL_P_L,
        MUL_I_L,
        MUL_D_L,
        MUL_P_R,
        MUL_I_R,
        MUL_D_R
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        step_t    step;
        mul_sel_t mul;
        acc_op_t  acc;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== src/cdd_cfg_regs.sv =====
// Configuration register file for the cascade differential-drive PID block.
// Depends on cdd_pkg for the register map and the cfg_t bundle.
`default_nettype none

module cdd_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cdd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [cdd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output cdd_pkg::cfg_t                         cfg
);

    cdd_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.error_to_diff_scale <= cdd_pkg::SCALE_RST;
            cfg_reg.diff_limit          <= cdd_pkg::DIFF_LIMIT_RST;
            cfg_reg.smoothing_weight    <= cdd_pkg::WEIGHT_RST;
            cfg_reg.prop_gain           <= cdd_pkg::PROP_GAIN_RST;
            cfg_reg.integ_gain          <= cdd_pkg::INTEG_GAIN_RST;
            cfg_reg.deriv_gain          <= cdd_pkg::DERIV_GAIN_RST;
            cfg_reg.integ_limit         <= cdd_pkg::INTEG_LIMIT_RST;
            cfg_reg.drive_limit         <= cdd_pkg::DRIVE_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cdd_pkg::REG_ERROR_TO_DIFF_SCALE: cfg_reg.error_to_diff_scale <= cfg_data[15:0];
                cdd_pkg::REG_DIFF_LIMIT:          cfg_reg.diff_limit          <= cfg_data[14:0];
                cdd_pkg::REG_SMOOTHING_WEIGHT:    cfg_reg.smoothing_weight    <= cfg_data[15:0];
                cdd_pkg::REG_PROP_GAIN:           cfg_reg.prop_gain           <= cfg_data[23:0];
                cdd_pkg::REG_INTEG_GAIN:          cfg_reg.integ_gain          <= cfg_data[23:0];
                cdd_pkg::REG_DERIV_GAIN:          cfg_reg.deriv_gain          <= cfg_data[23:0];
                cdd_pkg::REG_INTEG_LIMIT:         cfg_reg.integ_limit         <= cfg_data[22:0];
                cdd_pkg::REG_DRIVE_LIMIT:         cfg_reg.drive_limit         <= cfg_data[14:0];
                default:                          cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/cdd_datapath.sv =====
// Datapath of the cascade differential-drive PID block: input capture, one
// shared 25x25 multiplier, accumulator, filter and PID state, output registers.
// Depends on cdd_pkg; driven by cdd_ctrl through dp_cmd_t.
`default_nettype none

module cdd_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cdd_pkg::dp_cmd_t   cmd,
    input  wire cdd_pkg::cfg_t      cfg,
    input  wire logic signed [15:0] lateral_error,
    input  wire logic signed [15:0] forward_speed,
    input  wire logic signed [15:0] left_speed,
    input  wire logic signed [15:0] right_speed,
    output logic signed [15:0]      left_drive,
    output logic signed [15:0]      right_drive,
    output logic signed [15:0]      left_target,
    output logic signed [15:0]      right_target
);

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767)
            r = 16'sh7fff;
        else if (v < -17'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // captured item
    logic signed [15:0] lat_reg, fwd_reg, lspd_reg, rspd_reg;

    // working registers
    logic signed [49:0] prod_reg, prod_next;
    logic signed [49:0] acc_reg;
    logic signed [15:0] diff_reg, diff_next;
    logic signed [15:0] raw_l_reg, raw_r_reg;
    logic signed [16:0] delta_l_reg, delta_r_reg;
    logic signed [17:0] deriv_l_reg, deriv_r_reg;
    logic signed [15:0] drv_l_reg, drv_r_reg;

    // loop state
    logic signed [15:0] tgt_l_reg, tgt_r_reg;
    logic signed [16:0] err_l_reg, err_r_reg;
    logic signed [23:0] sum_l_reg, sum_r_reg;

    // result item
    logic signed [15:0] out_dl_reg, out_dr_reg, out_tl_reg, out_tr_reg;

    logic signed [24:0] mul_a, mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul)
            cdd_pkg::MUL_LAT:
            begin
                mul_a = $signed({9'd0, cfg.error_to_diff_scale});
                mul_b = $signed({{9{lat_reg[15]}}, lat_reg});
            end
            cdd_pkg::MUL_SMOOTH_L:
            begin
                mul_a = $signed({9'd0, cfg.smoothing_weight});
                mul_b = $signed({{8{delta_l_reg[16]}}, delta_l_reg});
            end
            cdd_pkg::MUL_SMOOTH_R:
            begin
                mul_a = $signed({9'd0, cfg.smoothing_weight});
                mul_b = $signed({{8{delta_r_reg[16]}}, delta_r_reg});
            end
            cdd_pkg::MUL_P_L:
            begin
                mul_a = $signed({1'b0, cfg.prop_gain});
                mul_b = $signed({{8{err_l_reg[16]}}, err_l_reg});
            end
            cdd_pkg::MUL_I_L:
            begin
                mul_a = $signed({1'b0, cfg.integ_gain});
                mul_b = $signed({sum_l_reg[23], sum_l_reg});
            end
            cdd_pkg::MUL_D_L:
            begin
                mul_a = $signed({1'b0, cfg.deriv_gain});
                mul_b = $signed({{7{deriv_l_reg[17]}}, deriv_l_reg});
            end
            cdd_pkg::MUL_P_R:
            begin
                mul_a = $signed({1'b0, cfg.prop_gain});
                mul_b = $signed({{8{err_r_reg[16]}}, err_r_reg});
            end
            cdd_pkg::MUL_I_R:
            begin
                mul_a = $signed({1'b0, cfg.integ_gain});
                mul_b = $signed({sum_r_reg[23], sum_r_reg});
            end
            cdd_pkg::MUL_D_R:
            begin
                mul_a = $signed({1'b0, cfg.deriv_gain});
                mul_b = $signed({{7{deriv_r_reg[17]}}, deriv_r_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // speed difference: round, then clamp to +/- diff_limit
    logic signed [32:0] lat_prod, diff_rnd, diff_lim, diff_sat;

    always_comb
    begin
        lat_prod = $signed(prod_reg[32:0]);
        diff_rnd = (lat_prod + 33'sd2048) >>> 12;
        diff_lim = $signed({18'd0, cfg.diff_limit});
        if (diff_rnd > diff_lim)
            diff_sat = diff_lim;
        else if (diff_rnd < -diff_lim)
            diff_sat = -diff_lim;
        else
            diff_sat = diff_rnd;
        diff_next = diff_sat[15:0];
    end

    // raw wheel targets
    logic signed [15:0] half;
    logic signed [16:0] raw_l_w, raw_r_w;

    assign half    = diff_reg >>> 1;
    assign raw_l_w = {fwd_reg[15], fwd_reg} - {half[15], half};
    assign raw_r_w = {fwd_reg[15], fwd_reg} + {half[15], half};

    // exponential smoothing correction
    logic signed [33:0] sm_rnd;

    assign sm_rnd = ($signed(prod_reg[33:0]) + 34'sd32768) >>> 16;

    // wheel errors and derivatives
    logic signed [16:0] err_l_new, err_r_new;

    assign err_l_new = {tgt_l_reg[15], tgt_l_reg} - {lspd_reg[15], lspd_reg};
    assign err_r_new = {tgt_r_reg[15], tgt_r_reg} - {rspd_reg[15], rspd_reg};

    // clamped error sums
    logic signed [24:0] sum_l_w, sum_r_w, ilim;
    logic signed [23:0] sum_l_next, sum_r_next;

    always_comb
    begin
        ilim    = $signed({2'b00, cfg.integ_limit});
        sum_l_w = {sum_l_reg[23], sum_l_reg} + {{8{err_l_reg[16]}}, err_l_reg};
        sum_r_w = {sum_r_reg[23], sum_r_reg} + {{8{err_r_reg[16]}}, err_r_reg};
        if (sum_l_w > ilim)
            sum_l_next = ilim[23:0];
        else if (sum_l_w < -ilim)
            sum_l_next = 24'(-ilim);
        else
            sum_l_next = sum_l_w[23:0];
        if (sum_r_w > ilim)
            sum_r_next = ilim[23:0];
        else if (sum_r_w < -ilim)
            sum_r_next = 24'(-ilim);
        else
            sum_r_next = sum_r_w[23:0];
    end

    // PID output: round away the Q24 fraction, clamp to drive_limit
    logic signed [49:0] drv_rnd, dlim, drv_sat;

    always_comb
    begin
        drv_rnd = (acc_reg + 50'sd8388608) >>> 24;
        dlim    = $signed({35'd0, cfg.drive_limit});
        if (drv_rnd > dlim)
            drv_sat = dlim;
        else if (drv_rnd < -dlim)
            drv_sat = -dlim;
        else
            drv_sat = drv_rnd;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul != cdd_pkg::MUL_NONE)
            prod_reg <= prod_next;

        case (cmd.acc)
            cdd_pkg::ACC_LOAD: acc_reg <= prod_reg;
            cdd_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_reg;
            default:           acc_reg <= acc_reg;
        endcase

        case (cmd.step)
            cdd_pkg::STEP_CAPTURE:
            begin
                lat_reg  <= lateral_error;
                fwd_reg  <= forward_speed;
                lspd_reg <= left_speed;
                rspd_reg <= right_speed;
            end
            cdd_pkg::STEP_DIFF:
                diff_reg <= diff_next;
            cdd_pkg::STEP_RAW:
            begin
                raw_l_reg <= sat16(raw_l_w);
                raw_r_reg <= sat16(raw_r_w);
            end
            cdd_pkg::STEP_DELTA:
            begin
                delta_l_reg <= {raw_l_reg[15], raw_l_reg} - {tgt_l_reg[15], tgt_l_reg};
                delta_r_reg <= {raw_r_reg[15], raw_r_reg} - {tgt_r_reg[15], tgt_r_reg};
            end
            cdd_pkg::STEP_ERR:
            begin
                deriv_l_reg <= {err_l_new[16], err_l_new} - {err_l_reg[16], err_l_reg};
                deriv_r_reg <= {err_r_new[16], err_r_new} - {err_r_reg[16], err_r_reg};
            end
            cdd_pkg::STEP_DRIVE_L:
                drv_l_reg <= drv_sat[15:0];
            cdd_pkg::STEP_DRIVE_R:
                drv_r_reg <= drv_sat[15:0];
            cdd_pkg::STEP_OUT:
            begin
                out_dl_reg <= drv_l_reg;
                out_dr_reg <= drv_r_reg;
                out_tl_reg <= tgt_l_reg;
                out_tr_reg <= tgt_r_reg;
            end
            default:
                diff_reg <= diff_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_l_reg <= '0;
            tgt_r_reg <= '0;
            err_l_reg <= '0;
            err_r_reg <= '0;
            sum_l_reg <= '0;
            sum_r_reg <= '0;
        end
        else
        begin
            case (cmd.step)
                cdd_pkg::STEP_TARGET_L:
                    tgt_l_reg <= tgt_l_reg + sm_rnd[15:0];
                cdd_pkg::STEP_TARGET_R:
                    tgt_r_reg <= tgt_r_reg + sm_rnd[15:0];
                cdd_pkg::STEP_ERR:
                begin
                    err_l_reg <= err_l_new;
                    err_r_reg <= err_r_new;
                end
                cdd_pkg::STEP_SUM:
                begin
                    sum_l_reg <= sum_l_next;
                    sum_r_reg <= sum_r_next;
                end
                default:
                    tgt_l_reg <= tgt_l_reg;
            endcase
        end
    end

    assign left_drive   = out_dl_reg;
    assign right_drive  = out_dr_reg;
    assign left_target  = out_tl_reg;
    assign right_target = out_tr_reg;

`ifndef ASSERT_OFF
    a_diff_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step == cdd_pkg::STEP_DIFF |=>
            diff_reg <= $signed({1'b0, $past(cfg.diff_limit)}) &&
            diff_reg >= -$signed({1'b0, $past(cfg.diff_limit)}))
        else $error("speed difference outside its limit");

    a_sum_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step == cdd_pkg::STEP_SUM |=>
            sum_l_reg <= $signed({1'b0, $past(cfg.integ_limit)}) &&
            sum_l_reg >= -$signed({1'b0, $past(cfg.integ_limit)}) &&
            sum_r_reg <= $signed({1'b0, $past(cfg.integ_limit)}) &&
            sum_r_reg >= -$signed({1'b0, $past(cfg.integ_limit)}))
        else $error("error sum outside integral limit");

    a_drive_l_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step == cdd_pkg::STEP_DRIVE_L |=>
            drv_l_reg <= $signed({1'b0, $past(cfg.drive_limit)}) &&
            drv_l_reg >= -$signed({1'b0, $past(cfg.drive_limit)}))
        else $error("left drive outside drive limit");

    a_drive_r_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step == cdd_pkg::STEP_DRIVE_R |=>
            drv_r_reg <= $signed({1'b0, $past(cfg.drive_limit)}) &&
            drv_r_reg >= -$signed({1'b0, $past(cfg.drive_limit)}))
        else $error("right drive outside drive limit");
`endif

endmodule

`default_nettype wire

// ===== src/cdd_ctrl.sv =====
// Sequencer of the cascade differential-drive PID block: runs the fixed
// schedule of one item and owns the input and output handshakes.
// Depends on cdd_pkg for dp_cmd_t.
`default_nettype none

module cdd_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output cdd_pkg::dp_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_LAT,
        ST_DIFF,
        ST_RAW,
        ST_DELTA,
        ST_SM_L,
        ST_TG_L,
        ST_TG_R,
        ST_ERR,
        ST_SUM,
        ST_MAC_IL,
        ST_MAC_DL,
        ST_MAC_PR,
        ST_MAC_IR,
        ST_MAC_DR,
        ST_MAC_END,
        ST_DRV_R,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.step   = cdd_pkg::STEP_NONE;
        cmd.mul    = cdd_pkg::MUL_NONE;
        cmd.acc    = cdd_pkg::ACC_HOLD;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.step   = cdd_pkg::STEP_CAPTURE;
                    state_next = ST_MUL_LAT;
                end
            end
            ST_MUL_LAT:
            begin
                cmd.mul    = cdd_pkg::MUL_LAT;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.step   = cdd_pkg::STEP_DIFF;
                state_next = ST_RAW;
            end
            ST_RAW:
            begin
                cmd.step   = cdd_pkg::STEP_RAW;
                state_next = ST_DELTA;
            end
            ST_DELTA:
            begin
                cmd.step   = cdd_pkg::STEP_DELTA;
                state_next = ST_SM_L;
            end
            ST_SM_L:
            begin
                cmd.mul    = cdd_pkg::MUL_SMOOTH_L;
                state_next = ST_TG_L;
            end
            ST_TG_L:
            begin
                cmd.step   = cdd_pkg::STEP_TARGET_L;
                cmd.mul    = cdd_pkg::MUL_SMOOTH_R;
                state_next = ST_TG_R;
            end
            ST_TG_R:
            begin
                cmd.step   = cdd_pkg::STEP_TARGET_R;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.step   = cdd_pkg::STEP_ERR;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.step   = cdd_pkg::STEP_SUM;
                cmd.mul    = cdd_pkg::MUL_P_L;
                state_next = ST_MAC_IL;
            end
            ST_MAC_IL:
            begin
                cmd.mul    = cdd_pkg::MUL_I_L;
                cmd.acc    = cdd_pkg::ACC_LOAD;
                state_next = ST_MAC_DL;
            end
            ST_MAC_DL:
            begin
                cmd.mul    = cdd_pkg::MUL_D_L;
                cmd.acc    = cdd_pkg::ACC_ADD;
                state_next = ST_MAC_PR;
            end
            ST_MAC_PR:
            begin
                cmd.mul    = cdd_pkg::MUL_P_R;
                cmd.acc    = cdd_pkg::ACC_ADD;
                state_next = ST_MAC_IR;
            end
            ST_MAC_IR:
            begin
                // left sum is complete here; right side reloads the accumulator
                cmd.step   = cdd_pkg::STEP_DRIVE_L;
                cmd.mul    = cdd_pkg::MUL_I_R;
                cmd.acc    = cdd_pkg::ACC_LOAD;
                state_next = ST_MAC_DR;
            end
            ST_MAC_DR:
            begin
                cmd.mul    = cdd_pkg::MUL_D_R;
                cmd.acc    = cdd_pkg::ACC_ADD;
                state_next = ST_MAC_END;
            end
            ST_MAC_END:
            begin
                cmd.acc    = cdd_pkg::ACC_ADD;
                state_next = ST_DRV_R;
            end
            ST_DRV_R:
            begin
                cmd.step   = cdd_pkg::STEP_DRIVE_R;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.step   = cdd_pkg::STEP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.step == cdd_pkg::STEP_OUT)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_MUL_LAT)
        else $error("accepted item did not start the schedule");

    a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && out_valid_reg && !out_ready |=>
            state_reg == ST_OUT && $stable(out_valid_reg))
        else $error("result overwrote an item not yet taken");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step == cdd_pkg::STEP_OUT |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// ===== src/cascade_diff_drive_pid_unit.sv =====
// Cascade differential-drive PID controller, one result item per input item.
// Instantiates cdd_cfg_regs, cdd_ctrl and cdd_datapath; depends on cdd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries lateral_error, forward_speed,
//   left_speed and right_speed for one control tick. Output channel
//   (out_valid/out_ready) returns left_drive, right_drive, left_target and
//   right_target. Configuration channel (cfg_valid/cfg_ready, cfg_index,
//   cfg_data) writes the eight gain and limit registers; cfg_ready is always
//   high and the 3-bit index names one of the eight registers. Write registers
//   only while no item is in flight.
//   An item is accepted only in idle, so a new item waits until the last one
//   has run the whole schedule on the single shared 25x25 multiplier, which
//   runs the scaling, both smoothing filters and the six PID products in
//   turn.
//   A finished result sits in an output register; the next item is accepted
//   while it waits. If the receiver stalls, the following item is held at its
//   last step until the output register frees up.
//   Reset loads the default gains and limits and clears targets, error sums
//   and previous errors; no item or result is pending afterwards.
`default_nettype none

module cascade_diff_drive_pid_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic signed [15:0]               lateral_error,
    input  wire logic signed [15:0]               forward_speed,
    input  wire logic signed [15:0]               left_speed,
    input  wire logic signed [15:0]               right_speed,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [15:0]                    left_drive,
    output logic signed [15:0]                    right_drive,
    output logic signed [15:0]                    left_target,
    output logic signed [15:0]                    right_target,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cdd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [cdd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    cdd_pkg::cfg_t    cfg;
    cdd_pkg::dp_cmd_t cmd;

    cdd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cdd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    cdd_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg),
        .lateral_error (lateral_error),
        .forward_speed (forward_speed),
        .left_speed    (left_speed),
        .right_speed   (right_speed),
        .left_drive    (left_drive),
        .right_drive   (right_drive),
        .left_target   (left_target),
        .right_target  (right_target)
    );

endmodule

`default_nettype wire
